// ===== rtl/core/rbt_pkg.sv =====
// Shared types, constants and a helper function for the ROI binary threshold block.
package rbt_pkg;

    localparam int MAX_DIM = 4096;
    localparam int CNT_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = CNT_W + 1;
    localparam int PIX_W   = 8;
    localparam int IMG_W   = 13;
    localparam int REG_W   = 14;
    localparam int IDX_W   = 3;
    localparam int EXT_W   = IMG_W + DIM_W;
    localparam int SPAN_W  = ((DIM_W > REG_W - 1) ? DIM_W : (REG_W - 1)) + 1;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
    localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

    localparam logic [PIX_W-1:0] RST_THRESHOLD = 8'd128;
    localparam logic [IMG_W-1:0] RST_WIDTH     = 13'd640;
    localparam logic [IMG_W-1:0] RST_HEIGHT    = 13'd480;

    typedef enum logic [IDX_W-1:0] {
        CFG_THRESHOLD     = 3'd0,
        CFG_IMAGE_WIDTH   = 3'd1,
        CFG_IMAGE_HEIGHT  = 3'd2,
        CFG_REGION_LEFT   = 3'd3,
        CFG_REGION_TOP    = 3'd4,
        CFG_REGION_WIDTH  = 3'd5,
        CFG_REGION_HEIGHT = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0]        threshold;
        logic [IMG_W-1:0]        image_width;
        logic [IMG_W-1:0]        image_height;
        logic signed [REG_W-1:0] region_left;
        logic signed [REG_W-1:0] region_top;
        logic signed [REG_W-1:0] region_width;
        logic signed [REG_W-1:0] region_height;
    } t_cfg;

    typedef struct packed {
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] bottom;
    } t_bounds;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [IMG_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0) begin
            d = DIM_W'(1);
        end else if (EXT_W'(v) > EXT_W'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/rbt_bounds.sv =====
// Region bounds: clamps the region into the frame (else whole frame), registered.
module rbt_bounds (
    input  logic            i_clk,
    input  rbt_pkg::t_cfg   i_cfg,
    output rbt_pkg::t_bounds o_bounds
);

    function automatic logic [2*rbt_pkg::DIM_W-1:0] clamp_span(
        input logic signed [rbt_pkg::REG_W-1:0] origin,
        input logic signed [rbt_pkg::REG_W-1:0] extent,
        input logic [rbt_pkg::DIM_W-1:0]        dim
    );
        logic [rbt_pkg::SPAN_W-1:0] o;
        logic [rbt_pkg::SPAN_W-1:0] room;
        logic [rbt_pkg::SPAN_W-1:0] ext;
        logic [rbt_pkg::SPAN_W-1:0] sum;
        logic [rbt_pkg::DIM_W-1:0]  hi;
        if (origin[rbt_pkg::REG_W-1]) begin
            o = '0;
        end else if (rbt_pkg::SPAN_W'(origin[rbt_pkg::REG_W-2:0]) >
                     rbt_pkg::SPAN_W'(dim)) begin
            o = rbt_pkg::SPAN_W'(dim);
        end else begin
            o = rbt_pkg::SPAN_W'(origin[rbt_pkg::REG_W-2:0]);
        end
        room = rbt_pkg::SPAN_W'(dim) - o;
        ext  = rbt_pkg::SPAN_W'(extent[rbt_pkg::REG_W-2:0]);
        sum  = o + ext;
        if (ext > room) begin
            hi = dim;
        end else begin
            hi = rbt_pkg::DIM_W'(sum);
        end
        return {rbt_pkg::DIM_W'(o), hi};
    endfunction

    logic [rbt_pkg::DIM_W-1:0]   w;
    logic [rbt_pkg::DIM_W-1:0]   h;
    logic                        region_on;
    logic [2*rbt_pkg::DIM_W-1:0] span_x;
    logic [2*rbt_pkg::DIM_W-1:0] span_y;
    rbt_pkg::t_bounds            n_bounds;
    rbt_pkg::t_bounds            r_bounds;

    always_comb begin
        w = rbt_pkg::eff_dim(i_cfg.image_width);
        h = rbt_pkg::eff_dim(i_cfg.image_height);
        region_on = !i_cfg.region_width[rbt_pkg::REG_W-1] && (i_cfg.region_width != '0) &&
                    !i_cfg.region_height[rbt_pkg::REG_W-1] && (i_cfg.region_height != '0);
        span_x = clamp_span(i_cfg.region_left, i_cfg.region_width, w);
        span_y = clamp_span(i_cfg.region_top, i_cfg.region_height, h);
        if (region_on) begin
            n_bounds.left   = span_x[2*rbt_pkg::DIM_W-1:rbt_pkg::DIM_W];
            n_bounds.right  = span_x[rbt_pkg::DIM_W-1:0];
            n_bounds.top    = span_y[2*rbt_pkg::DIM_W-1:rbt_pkg::DIM_W];
            n_bounds.bottom = span_y[rbt_pkg::DIM_W-1:0];
        end else begin
            n_bounds.left   = '0;
            n_bounds.right  = w;
            n_bounds.top    = '0;
            n_bounds.bottom = h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bounds <= n_bounds;
    end

    assign o_bounds = r_bounds;

endmodule

// ===== rtl/core/roi_binary_threshold.sv =====
// Top level of the ROI binary threshold pixel stream block.
// Pipeline: input stage, then result register.
// Throughput: 1 pixel per cycle while the output is ready; the counters and four bound compares set the stage.
// Reset: synchronous, active low; counters clear and configuration and valid registers take their reset values.
// Region bounds follow a configuration write through the configuration register and then the bounds register.
module roi_binary_threshold (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [rbt_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [rbt_pkg::REG_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rbt_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rbt_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_frame_end
);

    rbt_pkg::t_cfg               r_cfg;
    rbt_pkg::t_bounds            bounds;

    logic [rbt_pkg::CNT_W-1:0]   r_col;
    logic [rbt_pkg::CNT_W-1:0]   r_row;
    logic [rbt_pkg::CNT_W-1:0]   n_col;
    logic [rbt_pkg::CNT_W-1:0]   n_row;
    logic [rbt_pkg::DIM_W-1:0]   w;
    logic [rbt_pkg::DIM_W-1:0]   h;
    logic                        last_col;
    logic                        last_row;

    logic                        r_s1_vld;
    logic [rbt_pkg::PIX_W-1:0]   r_s1_pix;
    logic [rbt_pkg::CNT_W-1:0]   r_s1_col;
    logic [rbt_pkg::CNT_W-1:0]   r_s1_row;
    logic                        r_s1_end;

    logic                        r_out_vld;
    logic [rbt_pkg::PIX_W-1:0]   r_out_pix;
    logic                        r_out_end;

    logic                        in_fire;
    logic                        s1_adv;
    logic                        in_region;
    logic [rbt_pkg::DIM_W-1:0]   s1_col_x;
    logic [rbt_pkg::DIM_W-1:0]   s1_row_x;
    logic [rbt_pkg::PIX_W-1:0]   n_out_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold     <= rbt_pkg::RST_THRESHOLD;
            r_cfg.image_width   <= rbt_pkg::RST_WIDTH;
            r_cfg.image_height  <= rbt_pkg::RST_HEIGHT;
            r_cfg.region_left   <= '0;
            r_cfg.region_top    <= '0;
            r_cfg.region_width  <= '0;
            r_cfg.region_height <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                rbt_pkg::CFG_THRESHOLD:     r_cfg.threshold     <= i_cfg_wdata[rbt_pkg::PIX_W-1:0];
                rbt_pkg::CFG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_wdata[rbt_pkg::IMG_W-1:0];
                rbt_pkg::CFG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg_wdata[rbt_pkg::IMG_W-1:0];
                rbt_pkg::CFG_REGION_LEFT:   r_cfg.region_left   <= i_cfg_wdata;
                rbt_pkg::CFG_REGION_TOP:    r_cfg.region_top    <= i_cfg_wdata;
                rbt_pkg::CFG_REGION_WIDTH:  r_cfg.region_width  <= i_cfg_wdata;
                rbt_pkg::CFG_REGION_HEIGHT: r_cfg.region_height <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    rbt_bounds u_bounds (
        .i_clk    (i_clk),
        .i_cfg    (r_cfg),
        .o_bounds (bounds)
    );

    // advance raster position on each input beat
    always_comb begin
        w = rbt_pkg::eff_dim(r_cfg.image_width);
        h = rbt_pkg::eff_dim(r_cfg.image_height);
        last_col = ({1'b0, r_col} + rbt_pkg::DIM_W'(1)) >= w;
        last_row = ({1'b0, r_row} + rbt_pkg::DIM_W'(1)) >= h;
        n_col = r_col;
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + rbt_pkg::CNT_W'(1);
        end else begin
            n_col = r_col + rbt_pkg::CNT_W'(1);
        end
    end

    assign s1_adv     = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || !r_out_vld || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_s1_vld <= 1'b0;
        end else begin
            if (in_fire) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pix <= i_pixel_in;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s1_end <= last_col && last_row;
        end
    end

    always_comb begin
        s1_col_x = {1'b0, r_s1_col};
        s1_row_x = {1'b0, r_s1_row};
        in_region = (s1_col_x >= bounds.left) && (s1_col_x < bounds.right) &&
                    (s1_row_x >= bounds.top) && (s1_row_x < bounds.bottom);
        if (in_region) begin
            n_out_pix = (r_s1_pix > r_cfg.threshold) ? rbt_pkg::PIX_MAX : rbt_pkg::PIX_MIN;
        end else begin
            n_out_pix = r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pix <= n_out_pix;
            r_out_end <= r_s1_end;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_pixel_out = r_out_pix;
    assign o_frame_end = r_out_end;

`ifndef ASSERT_OFF
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && last_col && last_row) |=> (r_col == '0 && r_row == '0))
        else $error("raster position did not wrap at frame end");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_vld)
        else $error("advanced beat missing from result register");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the ROI binary threshold pixel stream block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [rbt_pkg::IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int MAX_REPORTS  = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_TAIL    = 80;
    localparam int SETTLE       = 4;

    class threshold_scoreboard;
        typedef struct {
            logic [rbt_pkg::PIX_W-1:0] pixel;
            logic                      frame_end;
        } t_out_beat;

        logic [rbt_pkg::PIX_W-1:0]        threshold     = rbt_pkg::RST_THRESHOLD;
        logic [rbt_pkg::IMG_W-1:0]        image_width   = rbt_pkg::RST_WIDTH;
        logic [rbt_pkg::IMG_W-1:0]        image_height  = rbt_pkg::RST_HEIGHT;
        logic signed [rbt_pkg::REG_W-1:0] region_left   = '0;
        logic signed [rbt_pkg::REG_W-1:0] region_top    = '0;
        logic signed [rbt_pkg::REG_W-1:0] region_width  = '0;
        logic signed [rbt_pkg::REG_W-1:0] region_height = '0;
        int                               column_count  = 0;
        int                               row_count     = 0;
        t_out_beat                        pending_beats[$];
        int                               errors        = 0;

        function void write_reg(logic [rbt_pkg::IDX_W-1:0] idx,
                                logic [rbt_pkg::REG_W-1:0] data);
            case (idx)
                rbt_pkg::CFG_THRESHOLD:     threshold     = data[rbt_pkg::PIX_W-1:0];
                rbt_pkg::CFG_IMAGE_WIDTH:   image_width   = data[rbt_pkg::IMG_W-1:0];
                rbt_pkg::CFG_IMAGE_HEIGHT:  image_height  = data[rbt_pkg::IMG_W-1:0];
                rbt_pkg::CFG_REGION_LEFT:   region_left   = data;
                rbt_pkg::CFG_REGION_TOP:    region_top    = data;
                rbt_pkg::CFG_REGION_WIDTH:  region_width  = data;
                rbt_pkg::CFG_REGION_HEIGHT: region_height = data;
                default: ;
            endcase
        endfunction

        function int frame_dim(logic [rbt_pkg::IMG_W-1:0] v);
            if (v == 0) return 1;
            if (v > rbt_pkg::MAX_DIM) return rbt_pkg::MAX_DIM;
            return int'(v);
        endfunction

        function void clamp_span(int origin, int extent, int dim, output int lo, output int hi);
            lo = (origin < 0) ? 0 : ((origin > dim) ? dim : origin);
            hi = (extent > dim - lo) ? dim : lo + extent;
        endfunction

        function int outstanding();
            return pending_beats.size();
        endfunction

        function void note_pixel(logic [rbt_pkg::PIX_W-1:0] pix);
            int        w;
            int        h;
            int        rw;
            int        rh;
            int        left;
            int        right;
            int        top;
            int        bottom;
            bit        last_col;
            bit        last_row;
            t_out_beat beat;
            w  = frame_dim(image_width);
            h  = frame_dim(image_height);
            rw = int'(region_width);
            rh = int'(region_height);
            if (rw <= 0 || rh <= 0) begin
                left = 0;
                right = w;
                top = 0;
                bottom = h;
            end else begin
                clamp_span(int'(region_left), rw, w, left, right);
                clamp_span(int'(region_top), rh, h, top, bottom);
            end
            beat.pixel = pix;
            if (column_count >= left && column_count < right &&
                row_count >= top && row_count < bottom) begin
                beat.pixel = (pix > threshold) ? rbt_pkg::PIX_MAX : rbt_pkg::PIX_MIN;
            end
            last_col = (column_count + 1 >= w);
            last_row = (row_count + 1 >= h);
            beat.frame_end = last_col && last_row;
            pending_beats.push_back(beat);
            if (last_col) begin
                column_count = 0;
                row_count = last_row ? 0 : row_count + 1;
            end else begin
                column_count++;
            end
        endfunction

        function void report(string what, int exp_val, int act_val);
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("mismatch on %s: expected %0d, got %0d", what, exp_val, act_val);
            end
        endfunction

        function void check_result(logic [rbt_pkg::PIX_W-1:0] pix, logic fe);
            t_out_beat beat;
            if (pending_beats.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected output beat: pixel %0d frame_end %0d", pix, fe);
                end
                return;
            end
            beat = pending_beats.pop_front();
            if (pix !== beat.pixel) report("pixel_out", beat.pixel, pix);
            if (fe !== beat.frame_end) report("frame_end", beat.frame_end, fe);
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [rbt_pkg::IDX_W-1:0] i_cfg_idx = '0;
    logic [rbt_pkg::REG_W-1:0] i_cfg_wdata = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [rbt_pkg::PIX_W-1:0] i_pixel_in = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [rbt_pkg::PIX_W-1:0] o_pixel_out;
    logic                      o_frame_end;

    threshold_scoreboard sb = new();
    bit                  quiet = 1'b0;
    int                  stall_left = 0;
    int                  cycles = 0;

    roi_binary_threshold DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pixel_out (o_pixel_out),
        .o_frame_end (o_frame_end)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_pixel(i_pixel_in);
            if (o_out_valid && i_out_ready) sb.check_result(o_pixel_out, o_frame_end);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready = 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready = 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_pixel(input logic [rbt_pkg::PIX_W-1:0] pix);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_pixel_in = pix;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [rbt_pkg::IDX_W-1:0] idx,
                             input logic [rbt_pkg::REG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        sb.write_reg(idx, data);
    endtask

    task automatic cfg_close();
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        repeat (2) @(negedge i_clk);
    endtask

    function automatic logic [rbt_pkg::REG_W-1:0] random_dim();
        case ($urandom_range(0, 9))
            0: return rbt_pkg::REG_W'($urandom);
            1: return '0;
            2: return rbt_pkg::REG_W'(rbt_pkg::MAX_DIM);
            default: return rbt_pkg::REG_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [rbt_pkg::REG_W-1:0] random_origin();
        case ($urandom_range(0, 7))
            0: return rbt_pkg::REG_W'($urandom);
            1: return rbt_pkg::REG_W'(-$urandom_range(1, 5));
            default: return rbt_pkg::REG_W'($urandom_range(0, 14));
        endcase
    endfunction

    function automatic logic [rbt_pkg::REG_W-1:0] random_extent();
        case ($urandom_range(0, 7))
            0: return rbt_pkg::REG_W'($urandom);
            1: return '0;
            2: return rbt_pkg::REG_W'(-$urandom_range(1, 3));
            default: return rbt_pkg::REG_W'($urandom_range(1, 10));
        endcase
    endfunction

    function automatic logic [rbt_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0: return rbt_pkg::PIX_MIN;
            1: return rbt_pkg::PIX_MAX;
            2: return sb.threshold;
            3: return sb.threshold + 8'd1;
            default: return rbt_pkg::PIX_W'($urandom);
        endcase
    endfunction

    initial begin
        int sent;
        int n;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // six pixels at reset settings (region is the whole frame), threshold boundary
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd128);
        send_pixel(8'd129);
        send_pixel(8'd127);
        send_pixel(8'd1);
        drain();

        // shrink frame under a live column, negative origin, oversize extent
        cfg_write(rbt_pkg::CFG_THRESHOLD, 14'd0);
        cfg_write(rbt_pkg::CFG_IMAGE_WIDTH, 14'd4);
        cfg_write(rbt_pkg::CFG_IMAGE_HEIGHT, 14'd2);
        cfg_write(rbt_pkg::CFG_REGION_LEFT, -14'sd3);
        cfg_write(rbt_pkg::CFG_REGION_TOP, 14'd1);
        cfg_write(rbt_pkg::CFG_REGION_WIDTH, 14'd100);
        cfg_write(rbt_pkg::CFG_REGION_HEIGHT, 14'd1);
        cfg_close();
        send_pixel(8'd0);
        send_pixel(8'd1);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd2);
        send_pixel(8'd1);
        send_pixel(8'd0);
        send_pixel(8'd200);
        drain();

        // zero frame size, origin past the edge, unused register index
        cfg_write(rbt_pkg::CFG_IMAGE_WIDTH, 14'd0);
        cfg_write(rbt_pkg::CFG_IMAGE_HEIGHT, 14'd0);
        cfg_write(rbt_pkg::CFG_THRESHOLD, 14'd255);
        cfg_write(rbt_pkg::CFG_REGION_LEFT, 14'd5);
        cfg_write(rbt_pkg::CFG_REGION_WIDTH, 14'd2);
        cfg_write(rbt_pkg::CFG_REGION_HEIGHT, 14'd2);
        cfg_write(CFG_UNUSED_IDX, 14'h3FFF);
        cfg_close();
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd77);
        drain();

        // oversize frame, nonpositive region width
        cfg_write(rbt_pkg::CFG_IMAGE_WIDTH, 14'h1FFF);
        cfg_write(rbt_pkg::CFG_IMAGE_HEIGHT, 14'd4096);
        cfg_write(rbt_pkg::CFG_REGION_LEFT, 14'h1FFF);
        cfg_write(rbt_pkg::CFG_REGION_TOP, 14'h3000);
        cfg_write(rbt_pkg::CFG_REGION_WIDTH, 14'h3FFF);
        cfg_write(rbt_pkg::CFG_REGION_HEIGHT, 14'd5);
        cfg_write(rbt_pkg::CFG_THRESHOLD, 14'd254);
        cfg_close();
        send_pixel(8'd254);
        send_pixel(8'd255);
        send_pixel(8'd0);
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            quiet = (sent >= RANDOM_ITEMS - CALM_TAIL) || ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 1))
                cfg_write(rbt_pkg::CFG_THRESHOLD, rbt_pkg::REG_W'($urandom));
            if ($urandom_range(0, 1)) cfg_write(rbt_pkg::CFG_IMAGE_WIDTH, random_dim());
            if ($urandom_range(0, 1)) cfg_write(rbt_pkg::CFG_IMAGE_HEIGHT, random_dim());
            if ($urandom_range(0, 1)) cfg_write(rbt_pkg::CFG_REGION_LEFT, random_origin());
            if ($urandom_range(0, 1)) cfg_write(rbt_pkg::CFG_REGION_TOP, random_origin());
            if ($urandom_range(0, 1)) cfg_write(rbt_pkg::CFG_REGION_WIDTH, random_extent());
            if ($urandom_range(0, 1)) cfg_write(rbt_pkg::CFG_REGION_HEIGHT, random_extent());
            if ($urandom_range(0, 7) == 0)
                cfg_write(CFG_UNUSED_IDX, rbt_pkg::REG_W'($urandom));
            cfg_close();
            n = $urandom_range(8, 40);
            repeat (n) send_pixel(random_pixel());
            sent += n;
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
